// ===== src/scb_pkg.sv =====
package scb_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_PINS_DEF  = 32;
	localparam int ENDPOINTS_DEF = 2;

	// Fixed field widths
	localparam int BYTE_BITS   = 8;
	localparam int BIT_IDX_W   = $clog2(BYTE_BITS);
	localparam int POS_W       = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int SLOT_IN_W   = 5;
	localparam int BUTTON_IN_W = 7;
	localparam int BUTTON_W    = 6;
	localparam int VALUE_W     = 16;
	localparam int ENTRY_W     = BUTTON_IN_W + VALUE_W;
	localparam int PINS_W      = 6;
	localparam int EPCOUNT_W   = 2;

	// Queue depths
	localparam int JQ_DEPTH    = 4;
	localparam int JQ_PTR_W    = $clog2(JQ_DEPTH);
	localparam int JQ_CNT_W    = $clog2(JQ_DEPTH + 1);
	localparam int OQ_DEPTH    = 16;
	localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

	// Action codes
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BIT   = 2'd1;
	localparam logic [1:0] ACT_MAP   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENDPOINT_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FIRST     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PINS_FIRST     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_SECOND    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PINS_SECOND    = 3'd6;

	// Configuration reset values
	localparam logic [POS_W-1:0]     RST_CHAIN_LENGTH   = 8'd16;
	localparam logic [EPCOUNT_W-1:0] RST_ENDPOINT_COUNT = 2'd1;
	localparam logic [PINS_W-1:0]    RST_PINS           = 6'd16;

	// Position ranges owned by each endpoint
	typedef struct packed {
		logic             en0;
		logic             en1;
		logic [POS_W-1:0] start0;
		logic [POS_W-1:0] end0;
		logic [POS_W-1:0] start1;
		logic [POS_W-1:0] end1;
	} bounds_t;

	typedef struct packed {
		logic             hit;
		logic             ep;
		logic [POS_W-1:0] off;
	} loc_t;

	// One unit of work for the lookup sequencer
	typedef struct packed {
		logic                 is_write;
		logic [BYTE_BITS-1:0] mask;
		logic [POS_W-1:0]     base;
		logic                 wr_ep;
		logic [SLOT_IN_W-1:0] wr_slot;
		logic [ENTRY_W-1:0]   wr_entry;
	} job_t;

	typedef struct packed {
		logic                endpoint;
		logic [BUTTON_W-1:0] button;
		logic [VALUE_W-1:0]  value;
		logic                last;
	} result_t;

	// Endpoint and slot owning a logical position
	function automatic loc_t locate(bounds_t b, logic [POS_W-1:0] pos);
		loc_t r;
		r.hit = 1'b0;
		r.ep  = 1'b0;
		r.off = '0;
		if (b.en0 && pos >= b.start0 && pos < b.end0) begin
			r.hit = 1'b1;
			r.off = pos - b.start0;
		end else if (b.en1 && pos >= b.start1 && pos < b.end1) begin
			r.hit = 1'b1;
			r.ep  = 1'b1;
			r.off = pos - b.start1;
		end
		return r;
	endfunction

endpackage

// ===== src/scb_layout.sv =====
module scb_layout #(
	parameter int MAX_PINS  = scb_pkg::MAX_PINS_DEF,
	parameter int ENDPOINTS = scb_pkg::ENDPOINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scb_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           descending,
	output scb_pkg::bounds_t               bounds
);
	import scb_pkg::*;

	logic [POS_W-1:0]     chain_length_q;
	logic                 descending_q;
	logic [EPCOUNT_W-1:0] endpoint_count_q;
	logic [POS_W-1:0]     skip_first_q;
	logic [PINS_W-1:0]    pins_first_q;
	logic [POS_W-1:0]     skip_second_q;
	logic [PINS_W-1:0]    pins_second_q;

	logic [POS_W-1:0] pins0_sat;
	logic [POS_W-1:0] pins1_sat;
	logic [POS_W-1:0] avail0;
	logic [POS_W-1:0] avail1;
	logic [POS_W-1:0] cnt0;
	logic [POS_W-1:0] cnt1;
	logic [POS_W-1:0] start1;
	logic [POS_W-1:0] end0;
	logic             ep0_on;
	logic             ep1_on;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_length_q   <= RST_CHAIN_LENGTH;
			descending_q     <= 1'b0;
			endpoint_count_q <= RST_ENDPOINT_COUNT;
			skip_first_q     <= '0;
			pins_first_q     <= RST_PINS;
			skip_second_q    <= '0;
			pins_second_q    <= RST_PINS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHAIN_LENGTH:   chain_length_q   <= cfg_data;
				CFG_DESCENDING:     descending_q     <= cfg_data[0];
				CFG_ENDPOINT_COUNT: endpoint_count_q <= cfg_data[EPCOUNT_W-1:0];
				CFG_SKIP_FIRST:     skip_first_q     <= cfg_data;
				CFG_PINS_FIRST:     pins_first_q     <= cfg_data[PINS_W-1:0];
				CFG_SKIP_SECOND:    skip_second_q    <= cfg_data;
				CFG_PINS_SECOND:    pins_second_q    <= cfg_data[PINS_W-1:0];
				default: ;
			endcase
		end
	end

	// Endpoint ranges: skips and pins both use up the chain length
	always_comb begin
		pins0_sat = (POS_W'(pins_first_q) > POS_W'(MAX_PINS)) ?
			POS_W'(MAX_PINS) : POS_W'(pins_first_q);
		pins1_sat = (POS_W'(pins_second_q) > POS_W'(MAX_PINS)) ?
			POS_W'(MAX_PINS) : POS_W'(pins_second_q);

		ep0_on = (endpoint_count_q != '0) && (skip_first_q < chain_length_q);
		avail0 = chain_length_q - skip_first_q;
		cnt0   = (avail0 > pins0_sat) ? pins0_sat : avail0;
		end0   = skip_first_q + cnt0;

		ep1_on = (ENDPOINTS >= 2) && (32'(endpoint_count_q) >= 2) && ep0_on
			&& (skip_second_q < (chain_length_q - end0));
		start1 = end0 + skip_second_q;
		avail1 = chain_length_q - start1;
		cnt1   = (avail1 > pins1_sat) ? pins1_sat : avail1;

		bounds.en0    = ep0_on;
		bounds.en1    = ep1_on;
		bounds.start0 = skip_first_q;
		bounds.end0   = end0;
		bounds.start1 = start1;
		bounds.end1   = start1 + cnt1;
	end

	assign descending = descending_q;

endmodule

// ===== src/scb_front.sv =====
module scb_front #(
	parameter int MAX_PINS  = scb_pkg::MAX_PINS_DEF,
	parameter int ENDPOINTS = scb_pkg::ENDPOINTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            action,
	input  logic                                  data_level,
	input  logic                                  map_endpoint,
	input  logic [scb_pkg::SLOT_IN_W-1:0]         map_slot,
	input  logic signed [scb_pkg::BUTTON_IN_W-1:0] map_button,
	input  logic signed [scb_pkg::VALUE_W-1:0]    map_value,
	input  logic                                  descending,
	input  scb_pkg::bounds_t                      bounds,
	output logic                                  job_valid,
	output scb_pkg::job_t                         job,
	input  logic                                  job_pop
);
	import scb_pkg::*;

	// Input register
	logic                   valid_s1;
	logic [1:0]             action_s1;
	logic                   level_s1;
	logic                   map_ep_s1;
	logic [SLOT_IN_W-1:0]   map_slot_s1;
	logic [ENTRY_W-1:0]     map_entry_s1;

	// Scan state
	logic [POS_W-1:0]       bit_pos_q;
	logic [BYTE_BITS-1:0]   byte_buf_q;

	// Job queue
	job_t                   jq_q [JQ_DEPTH];
	logic [JQ_PTR_W-1:0]    jq_wr_ptr_q;
	logic [JQ_PTR_W-1:0]    jq_rd_ptr_q;
	logic [JQ_CNT_W-1:0]    jq_count_q;

	logic                   pressed;
	logic [BIT_IDX_W-1:0]   k;
	logic                   byte_end;
	logic [BYTE_BITS-1:0]   nb;
	logic [POS_W-1:0]       base_desc;
	logic [BYTE_BITS-1:0]   mask_desc;
	logic [BYTE_BITS-1:0]   mask_asc;
	loc_t                   loc_asc;
	job_t                   new_job;
	logic                   jq_push;

	assign in_stall = jq_count_q >= JQ_CNT_W'(JQ_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && !in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1    <= action;
			level_s1     <= data_level;
			map_ep_s1    <= map_endpoint;
			map_slot_s1  <= map_slot;
			map_entry_s1 <= {map_button, map_value};
		end
	end

	// Positions that report in this transaction
	always_comb begin
		loc_t loc_i;
		pressed   = !level_s1;
		k         = bit_pos_q[BIT_IDX_W-1:0];
		byte_end  = (k == BIT_IDX_W'(BYTE_BITS - 1));
		nb        = byte_buf_q | (BYTE_BITS'(pressed) << k);
		base_desc = bit_pos_q & ~POS_W'(BYTE_BITS - 1);
		loc_asc   = locate(bounds, bit_pos_q);
		mask_asc  = BYTE_BITS'(pressed && loc_asc.hit);
		// reversed byte: bit received last is reported first
		for (int i = 0; i < BYTE_BITS; i++) begin
			loc_i = locate(bounds, base_desc + POS_W'(i));
			mask_desc[i] = nb[BYTE_BITS-1-i] && loc_i.hit;
		end
	end

	// Job build
	always_comb begin
		jq_push          = 1'b0;
		new_job.is_write = 1'b0;
		new_job.mask     = mask_asc;
		new_job.base     = bit_pos_q;
		new_job.wr_ep    = map_ep_s1;
		new_job.wr_slot  = map_slot_s1;
		new_job.wr_entry = map_entry_s1;
		if (valid_s1) begin
			unique case (action_s1)
				ACT_BIT: begin
					if (!descending) begin
						jq_push = (mask_asc != '0);
					end else begin
						new_job.mask = mask_desc;
						new_job.base = base_desc;
						jq_push      = byte_end && (mask_desc != '0);
					end
				end
				ACT_MAP: begin
					new_job.is_write = 1'b1;
					jq_push = (32'(map_ep_s1) < ENDPOINTS) && (32'(map_slot_s1) < MAX_PINS);
				end
				default: ;
			endcase
		end
	end

	// Bit counter and byte buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q  <= '0;
			byte_buf_q <= '0;
		end else if (valid_s1) begin
			unique case (action_s1)
				ACT_START: begin
					bit_pos_q  <= '0;
					byte_buf_q <= '0;
				end
				ACT_BIT: begin
					bit_pos_q <= bit_pos_q + POS_W'(1);
					if (descending) begin
						byte_buf_q <= byte_end ? '0 : nb;
					end
				end
				default: ;
			endcase
		end
	end

	// Job queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jq_wr_ptr_q <= '0;
			jq_rd_ptr_q <= '0;
			jq_count_q  <= '0;
		end else begin
			if (jq_push) begin
				jq_wr_ptr_q <= jq_wr_ptr_q + JQ_PTR_W'(1);
			end
			if (job_pop) begin
				jq_rd_ptr_q <= jq_rd_ptr_q + JQ_PTR_W'(1);
			end
			if (jq_push && !job_pop) begin
				jq_count_q <= jq_count_q + JQ_CNT_W'(1);
			end else if (!jq_push && job_pop) begin
				jq_count_q <= jq_count_q - JQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (jq_push) begin
			jq_q[jq_wr_ptr_q] <= new_job;
		end
	end

	assign job_valid = (jq_count_q != '0);
	assign job       = jq_q[jq_rd_ptr_q];

	// Checks
	a_jq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(jq_push && !job_pop) |-> (jq_count_q < JQ_CNT_W'(JQ_DEPTH)))
		else $error("job queue overflow");

	a_jq_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job popped from empty queue");

endmodule

// ===== src/scb_lookup.sv =====
module scb_lookup #(
	parameter int MAX_PINS  = scb_pkg::MAX_PINS_DEF,
	parameter int ENDPOINTS = scb_pkg::ENDPOINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  scb_pkg::bounds_t                   bounds,
	input  logic                               job_valid,
	input  scb_pkg::job_t                      job,
	output logic                               job_pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               endpoint,
	output logic [scb_pkg::BUTTON_W-1:0]       button,
	output logic signed [scb_pkg::VALUE_W-1:0] value,
	output logic                               last
);
	import scb_pkg::*;

	localparam int MAP_DEPTH = ENDPOINTS * MAX_PINS;
	localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

	// Pin map
	logic [ENTRY_W-1:0]   map_mem [MAP_DEPTH];

	logic [BYTE_BITS-1:0] done_q;
	logic [BYTE_BITS-1:0] rem;
	logic [BYTE_BITS-1:0] onehot;
	logic [BYTE_BITS-1:0] rest;
	logic [BIT_IDX_W-1:0] sel;
	logic [POS_W-1:0]     pos;
	loc_t                 loc;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    wr_addr;
	logic                 can_issue;
	logic                 issue_rd;
	logic                 do_wr;

	// Read stage
	logic                 valid_s2;
	logic                 end_s2;
	logic                 ep_s2;
	logic [ENTRY_W-1:0]   rdata_s2;
	logic                 cand;

	// Held result, waiting to learn whether it is the last one
	logic                 h_valid_q;
	logic                 h_fin_q;
	logic                 h_ep_q;
	logic [BUTTON_W-1:0]  h_button_q;
	logic [VALUE_W-1:0]   h_value_q;
	logic                 push;
	logic                 push_last;

	// Output queue
	result_t              oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]  oq_wr_ptr_q;
	logic [OQ_PTR_W-1:0]  oq_rd_ptr_q;
	logic [OQ_CNT_W-1:0]  oq_count_q;
	logic                 pop;
	result_t              head;

	// Pick the lowest pending position of the head job
	always_comb begin
		rem = job.mask & ~done_q;
		sel = '0;
		for (int i = BYTE_BITS - 1; i >= 0; i--) begin
			if (rem[i]) begin
				sel = BIT_IDX_W'(i);
			end
		end
		onehot  = BYTE_BITS'(1) << sel;
		rest    = rem & ~onehot;
		pos     = job.base + POS_W'(sel);
		loc     = locate(bounds, pos);
		rd_addr = ADDR_W'(32'(loc.ep) * MAX_PINS + 32'(loc.off));
		wr_addr = ADDR_W'(32'(job.wr_ep) * MAX_PINS + 32'(job.wr_slot));
	end

	// Room for the new lookup plus the read stage and the held result
	assign can_issue = oq_count_q <= OQ_CNT_W'(OQ_DEPTH - 3);
	assign issue_rd  = job_valid && !job.is_write && can_issue;
	assign do_wr     = job_valid && job.is_write;
	assign job_pop   = do_wr || (issue_rd && (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue_rd;
			if (job_pop) begin
				done_q <= '0;
			end else if (issue_rd) begin
				done_q <= done_q | onehot;
			end
		end
	end

	// Map write and registered read
	always_ff @(posedge clk) begin
		if (do_wr) begin
			map_mem[wr_addr] <= job.wr_entry;
		end
		if (issue_rd) begin
			rdata_s2 <= map_mem[rd_addr];
			ep_s2    <= loc.ep;
			end_s2   <= (rest == '0);
		end
	end

	// A mapped button gives a report
	assign cand      = valid_s2 && !rdata_s2[ENTRY_W-1];
	assign push      = h_valid_q && (h_fin_q || cand || (valid_s2 && end_s2));
	assign push_last = h_fin_q || (valid_s2 && end_s2 && !cand);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_q <= 1'b0;
			h_fin_q   <= 1'b0;
		end else if (cand) begin
			h_valid_q <= 1'b1;
			h_fin_q   <= end_s2;
		end else if (push) begin
			h_valid_q <= 1'b0;
			h_fin_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cand) begin
			h_ep_q     <= ep_s2;
			h_button_q <= rdata_s2[VALUE_W+BUTTON_W-1:VALUE_W];
			h_value_q  <= rdata_s2[VALUE_W-1:0];
		end
	end

	// Output queue
	assign out_valid = (oq_count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = oq_q[oq_rd_ptr_q];
	assign endpoint  = head.endpoint;
	assign button    = head.button;
	assign value     = head.value;
	assign last      = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_ptr_q <= '0;
			oq_rd_ptr_q <= '0;
			oq_count_q  <= '0;
		end else begin
			if (push) begin
				oq_wr_ptr_q <= oq_wr_ptr_q + OQ_PTR_W'(1);
			end
			if (pop) begin
				oq_rd_ptr_q <= oq_rd_ptr_q + OQ_PTR_W'(1);
			end
			if (push && !pop) begin
				oq_count_q <= oq_count_q + OQ_CNT_W'(1);
			end else if (!push && pop) begin
				oq_count_q <= oq_count_q - OQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			oq_q[oq_wr_ptr_q] <= '{endpoint: h_ep_q, button: h_button_q,
				value: h_value_q, last: push_last};
		end
	end

	// Checks
	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (oq_count_q < OQ_CNT_W'(OQ_DEPTH)))
		else $error("output queue overflow");

	a_end_empty_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && end_s2 && !cand) |=> !h_valid_q)
		else $error("held result kept after end of transaction");

	a_end_cand_final: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && end_s2 && cand) |=> (h_valid_q && h_fin_q))
		else $error("last report of transaction not marked final");

endmodule

// ===== src/shift_chain_button_scanner.sv =====
// A reversed byte releases its reports one per cycle while the lookup has output-queue room, the
// output rate set by the single map read port. Throughput: one input transaction per cycle while
// in_stall is low; one report per cycle through an output queue while out_stall is low.
// Reset: asynchronous, active low; clears configuration to defaults, the scan position, the
// byte buffer and all queues. The pin map is not cleared and holds nothing until written.
module shift_chain_button_scanner #(
	parameter int MAX_PINS  = scb_pkg::MAX_PINS_DEF,
	parameter int ENDPOINTS = scb_pkg::ENDPOINTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [scb_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [scb_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             action,
	input  logic                                   data_level,
	input  logic                                   map_endpoint,
	input  logic [scb_pkg::SLOT_IN_W-1:0]          map_slot,
	input  logic signed [scb_pkg::BUTTON_IN_W-1:0] map_button,
	input  logic signed [scb_pkg::VALUE_W-1:0]     map_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   endpoint,
	output logic [scb_pkg::BUTTON_W-1:0]           button,
	output logic signed [scb_pkg::VALUE_W-1:0]     value,
	output logic                                   last
);
	import scb_pkg::*;

	logic    descending;
	bounds_t bounds;
	logic    job_valid;
	job_t    job;
	logic    job_pop;

	scb_layout #(
		.MAX_PINS  (MAX_PINS),
		.ENDPOINTS (ENDPOINTS)
	) u_layout (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.descending (descending),
		.bounds     (bounds)
	);

	scb_front #(
		.MAX_PINS  (MAX_PINS),
		.ENDPOINTS (ENDPOINTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.data_level   (data_level),
		.map_endpoint (map_endpoint),
		.map_slot     (map_slot),
		.map_button   (map_button),
		.map_value    (map_value),
		.descending   (descending),
		.bounds       (bounds),
		.job_valid    (job_valid),
		.job          (job),
		.job_pop      (job_pop)
	);

	scb_lookup #(
		.MAX_PINS  (MAX_PINS),
		.ENDPOINTS (ENDPOINTS)
	) u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.bounds    (bounds),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.endpoint  (endpoint),
		.button    (button),
		.value     (value),
		.last      (last)
	);

endmodule
